@@ rtl/nfcrx_pkg.sv @@
// Shared types, codes and constants for the NFC response frame receiver.
`timescale 1ns / 1ps

package nfcrx_pkg;

  // Receive buffer size in bytes; reaching it without completion is an overflow.
  localparam int unsigned BUFFER_BYTES = 156;

  // Fixed byte positions within one exchange.
  localparam int unsigned ACK_BYTES   = 6;
  localparam int unsigned HEAD_END    = 9;   // first position after the frame header
  localparam int unsigned LEN_POS     = 9;   // position of the LEN byte
  localparam int unsigned SUM_FIRST   = 11;  // first frame byte
  localparam int unsigned PAY_FIRST   = 14;  // first payload byte (three frame bytes skipped)
  localparam int unsigned SKIP_BYTES  = 3;
  localparam int unsigned TAIL_BYTES  = 13;  // bytes outside the frame data in one exchange

  // ACK pattern and frame header pattern.
  localparam logic [7:0] ACK_PATTERN [ACK_BYTES] = '{8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
  localparam logic [7:0] HEAD_PATTERN [3] = '{8'h00, 8'h00, 8'hFF};

  // Timeout register reset value.
  localparam logic [15:0] TIMEOUT_RESET = 16'd2;

  // Input opcodes.
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2
  } opcode_t;

  // Result kinds.
  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } result_kind_t;

  // End-of-exchange status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_CHECKSUM = 3'd1,
    ST_ACK      = 3'd2,
    ST_HEADER   = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_TIMEOUT  = 3'd5
  } status_code_t;

  // Exchange phase, one-hot.
  typedef enum logic [1:0] {
    PH_IDLE = 2'b01,
    PH_RECV = 2'b10
  } phase_t;

  // One input item.
  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] byte_value;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic       result_kind;
    logic [7:0] payload_byte;
    logic       payload_last;
    logic [2:0] status_code;
    logic [7:0] payload_length;
  } out_item_t;

endpackage

@@ rtl/nfc_response_frame_receiver.sv @@
// Top level of the NFC response frame receiver.
// The block takes one item per clock cycle unless the output stalls: a start,
// a received byte or a time tick. An item passes through an input register, is
// parsed combinationally against the ACK, frame header, LEN, checksum and
// postamble layout, and its result (a payload byte or an end-of-exchange
// status) sits in an output register. The output register keeps taking items
// while its result is taken in the same cycle; only a stalled, full output
// register holds back the input. The timeout register is written through the
// cfg port, which is always ready.
`timescale 1ns / 1ps

module nfc_response_frame_receiver (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  nfcrx_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output nfcrx_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data
);
  import nfcrx_pkg::*;

  logic        item_valid;
  in_item_t    item;
  logic        free;
  logic        fire;
  logic        res_valid;
  out_item_t   res;
  logic [15:0] timeout_r;

  // Timeout register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout_r <= cfg_data;
    end
  end

  // An item is processed when the output register can take its result.
  assign fire = item_valid & free;

  nfcrx_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .advance    (free),
    .item_valid (item_valid),
    .item       (item)
  );

  nfcrx_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .item          (item),
    .timeout_ticks (timeout_r),
    .res_valid     (res_valid),
    .res           (res)
  );

  nfcrx_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .res_valid (res_valid),
    .res       (res),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ rtl/nfcrx_in_stage.sv @@
// Input register stage of the NFC response frame receiver.
`timescale 1ns / 1ps

module nfcrx_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  nfcrx_pkg::in_item_t in_data,
  input  logic              advance,
  output logic              item_valid,
  output nfcrx_pkg::in_item_t item
);
  import nfcrx_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     take;

  // The register takes a new transfer when empty or when its item moves on.
  assign in_stall  = valid_r & ~advance;
  assign take      = in_valid & ~in_stall;
  assign valid_nxt = take | (valid_r & ~advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_data;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ rtl/nfcrx_parser.sv @@
// Frame parsing state and per-item result logic of the NFC response frame receiver.
`timescale 1ns / 1ps

module nfcrx_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  nfcrx_pkg::in_item_t  item,
  input  logic [15:0]          timeout_ticks,
  output logic                 res_valid,
  output nfcrx_pkg::out_item_t res
);
  import nfcrx_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  byte_pos_r, byte_pos_nxt;
  logic [7:0]  frame_len_r, frame_len_nxt;
  logic [7:0]  run_sum_r, run_sum_nxt;
  logic        ack_mis_r, ack_mis_nxt;
  logic        hdr_mis_r, hdr_mis_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;

  logic [7:0]  b;
  logic [7:0]  len;
  logic [8:0]  pos9;
  logic [8:0]  len9;
  logic [8:0]  count;
  logic [2:0]  ack_idx;
  logic [1:0]  hdr_idx;
  logic        in_sum;
  logic        in_pay;
  logic        done;
  logic        ovf;

  assign b       = item.byte_value;
  assign pos9    = {1'b0, byte_pos_r};
  assign count   = pos9 + 9'd1;
  assign ack_idx = byte_pos_r[2:0];
  assign hdr_idx = 2'(byte_pos_r - 8'(ACK_BYTES));

  // The LEN byte is visible to the range checks in the cycle it arrives.
  assign len    = (byte_pos_r == 8'(LEN_POS)) ? b : frame_len_r;
  assign len9   = {1'b0, len};
  assign in_sum = (byte_pos_r >= 8'(SUM_FIRST)) && (pos9 <= len9 + 9'(SUM_FIRST));
  assign in_pay = (byte_pos_r >= 8'(PAY_FIRST)) && (pos9 <= len9 + 9'(SUM_FIRST - 1));
  assign done   = (count > 9'(HEAD_END)) && (len != 8'd0) && (count == len9 + 9'(TAIL_BYTES));
  assign ovf    = (count >= 9'(BUFFER_BYTES));

  // Next state and result for the item in the input register.
  always_comb begin
    phase_nxt     = phase_r;
    byte_pos_nxt  = byte_pos_r;
    frame_len_nxt = frame_len_r;
    run_sum_nxt   = run_sum_r;
    ack_mis_nxt   = ack_mis_r;
    hdr_mis_nxt   = hdr_mis_r;
    elapsed_nxt   = elapsed_r;
    res_valid     = 1'b0;
    res           = '0;

    case (item.opcode)
      OP_START: begin
        phase_nxt     = PH_RECV;
        byte_pos_nxt  = '0;
        frame_len_nxt = '0;
        run_sum_nxt   = '0;
        ack_mis_nxt   = 1'b0;
        hdr_mis_nxt   = 1'b0;
        elapsed_nxt   = '0;
      end
      OP_TICK: begin
        if (phase_r == PH_RECV) begin
          if (elapsed_r != 16'hFFFF) begin
            elapsed_nxt = elapsed_r + 16'd1;
          end
          if (elapsed_nxt >= timeout_ticks) begin
            res_valid       = 1'b1;
            res.result_kind = KIND_STATUS;
            res.status_code = ST_TIMEOUT;
            phase_nxt       = PH_IDLE;
          end
        end
      end
      OP_BYTE: begin
        if (phase_r == PH_RECV) begin
          // Pattern checks and LEN capture.
          if (byte_pos_r < 8'(ACK_BYTES)) begin
            if (b != ACK_PATTERN[ack_idx]) begin
              ack_mis_nxt = 1'b1;
            end
          end else if (byte_pos_r < 8'(HEAD_END)) begin
            if (b != HEAD_PATTERN[hdr_idx]) begin
              hdr_mis_nxt = 1'b1;
            end
          end else if (byte_pos_r == 8'(LEN_POS)) begin
            frame_len_nxt = b;
          end

          if (in_sum) begin
            run_sum_nxt = run_sum_r + b;
          end

          // Payload bytes pass straight out.
          if (in_pay) begin
            res_valid        = 1'b1;
            res.result_kind  = KIND_PAYLOAD;
            res.payload_byte = b;
            res.payload_last = (pos9 == len9 + 9'(SUM_FIRST - 1));
          end

          byte_pos_nxt = count[7:0];

          // Completion takes precedence over overflow and replaces a payload result.
          if (done) begin
            res_valid       = 1'b1;
            res             = '0;
            res.result_kind = KIND_STATUS;
            phase_nxt       = PH_IDLE;
            if (run_sum_nxt != 8'd0) begin
              res.status_code = ST_CHECKSUM;
            end else if (ack_mis_nxt) begin
              res.status_code = ST_ACK;
            end else if (hdr_mis_nxt) begin
              res.status_code = ST_HEADER;
            end else begin
              res.status_code    = ST_OK;
              res.payload_length = (len >= 8'(SKIP_BYTES)) ? len - 8'(SKIP_BYTES) : 8'd0;
            end
          end else if (ovf) begin
            res_valid       = 1'b1;
            res             = '0;
            res.result_kind = KIND_STATUS;
            res.status_code = ST_OVERFLOW;
            phase_nxt       = PH_IDLE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // State registers update only on an item that is processed, that is when fire is high.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      byte_pos_r  <= '0;
      frame_len_r <= '0;
      run_sum_r   <= '0;
      ack_mis_r   <= 1'b0;
      hdr_mis_r   <= 1'b0;
      elapsed_r   <= '0;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      byte_pos_r  <= byte_pos_nxt;
      frame_len_r <= frame_len_nxt;
      run_sum_r   <= run_sum_nxt;
      ack_mis_r   <= ack_mis_nxt;
      hdr_mis_r   <= hdr_mis_nxt;
      elapsed_r   <= elapsed_nxt;
    end
  end

endmodule

@@ rtl/nfcrx_out_stage.sv @@
// Result register stage of the NFC response frame receiver.
`timescale 1ns / 1ps

module nfcrx_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic                 res_valid,
  input  nfcrx_pkg::out_item_t res,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_stall,
  output nfcrx_pkg::out_item_t out_data
);
  import nfcrx_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  out_item_t data_r;

  // The register can load when empty or when its result transfers this cycle.
  assign free      = ~(valid_r & out_stall);
  assign valid_nxt = free ? (fire & res_valid) : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (free && fire && res_valid) begin
      data_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ dv/nfc_response_frame_receiver_tb.sv @@
// Self-checking testbench for the NFC response frame receiver with a predicting scoreboard.
`timescale 1ns / 1ps

module nfc_response_frame_receiver_tb;
  import nfcrx_pkg::*;

  // Opcode that the block must ignore; the package enum leaves it out.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned ITEM_TARGET = 1900;
  localparam int unsigned PHASE_COUNT = 6;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_GUARD = 20000;

  // Shapes of one response exchange as the controller might send it.
  typedef enum {
    EX_GOOD, EX_BAD_SUM, EX_BAD_ACK, EX_BAD_HEAD, EX_MIXED,
    EX_SHORT, EX_TRUNC, EX_RESTART, EX_ZERO, EX_LONG
  } exchange_kind_t;

  // Tracks the exchange state and holds the results the block still owes.
  class response_tracker;
    logic [15:0]  timeout_limit;
    phase_t       rx_phase;
    logic [7:0]   byte_pos;
    logic [7:0]   frame_len;
    logic [7:0]   frame_sum;
    bit           ack_bad;
    bit           head_bad;
    logic [15:0]  elapsed;
    out_item_t    awaited_results[$];
    int           errors;

    function new();
      timeout_limit = TIMEOUT_RESET;
      rx_phase = PH_IDLE;
      clear_exchange();
      errors = 0;
    endfunction

    function void clear_exchange();
      byte_pos = '0;
      frame_len = '0;
      frame_sum = '0;
      ack_bad = 1'b0;
      head_bad = 1'b0;
      elapsed = '0;
    endfunction

    // An end-of-exchange status closes the exchange.
    function void push_status(status_code_t code, logic [7:0] length);
      out_item_t res;
      res = '0;
      res.result_kind = KIND_STATUS;
      res.status_code = code;
      res.payload_length = length;
      awaited_results.push_back(res);
      rx_phase = PH_IDLE;
    endfunction

    // Works out what one accepted input item makes the block produce.
    function void predict_response(in_item_t item);
      out_item_t   res;
      bit          has_res;
      int unsigned p;
      int unsigned count;
      int unsigned len;
      res = '0;
      has_res = 1'b0;
      if (item.opcode == OP_START) begin
        clear_exchange();
        rx_phase = PH_RECV;
        return;
      end
      if (rx_phase != PH_RECV || item.opcode == OP_UNUSED) return;

      // A tick counts toward the timeout, saturating at the counter's top.
      if (item.opcode == OP_TICK) begin
        if (elapsed != 16'hFFFF) elapsed++;
        if (elapsed >= timeout_limit) push_status(ST_TIMEOUT, 8'd0);
        return;
      end

      // Received byte: pattern checks, LEN capture and the checksum.
      p = byte_pos;
      if (p < ACK_BYTES) begin
        if (item.byte_value != ACK_PATTERN[p]) ack_bad = 1'b1;
      end else if (p < HEAD_END) begin
        if (item.byte_value != HEAD_PATTERN[p - ACK_BYTES]) head_bad = 1'b1;
      end else if (p == LEN_POS) begin
        frame_len = item.byte_value;
      end
      len = frame_len;
      if (p >= SUM_FIRST && p <= SUM_FIRST + len) frame_sum += item.byte_value;

      // Frame bytes after the skipped ones go out as payload.
      if (p >= PAY_FIRST && p < SUM_FIRST + len) begin
        res.result_kind = KIND_PAYLOAD;
        res.payload_byte = item.byte_value;
        res.payload_last = (p == SUM_FIRST + len - 1);
        has_res = 1'b1;
      end

      count = p + 1;
      byte_pos = count[7:0];

      // Completion wins over overflow; a status replaces any payload byte.
      if (count > LEN_POS && len != 0 && count == len + TAIL_BYTES) begin
        if (frame_sum != 0) push_status(ST_CHECKSUM, 8'd0);
        else if (ack_bad) push_status(ST_ACK, 8'd0);
        else if (head_bad) push_status(ST_HEADER, 8'd0);
        else push_status(ST_OK, (len >= SKIP_BYTES) ? 8'(len - SKIP_BYTES) : 8'd0);
      end else if (count >= BUFFER_BYTES) begin
        push_status(ST_OVERFLOW, 8'd0);
      end else if (has_res) begin
        awaited_results.push_back(res);
      end
    endfunction

    function void field_check(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // Compares one result transfer with the oldest expectation.
    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited_results.size() == 0) begin
        $error("Result transfer with no result expected: %h", got);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      field_check("result_kind", want.result_kind, got.result_kind);
      field_check("payload_byte", want.payload_byte, got.payload_byte);
      field_check("payload_last", want.payload_last, got.payload_last);
      field_check("status_code", want.status_code, got.status_code);
      field_check("payload_length", want.payload_length, got.payload_length);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  response_tracker sb = new();
  int unsigned burst_left = 0;
  int unsigned items_done = 0;
  bit          hold_request = 1'b0;

  nfc_response_frame_receiver DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Observe every transfer at the rising edge; results are checked before the
  // new input is predicted so a fresh expectation never meets an older result.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.predict_response(in_data);
      if (cfg_valid && cfg_ready) sb.timeout_limit = cfg_data;
    end
  end

  // Receiver stall pattern, with a long hold-off when the stimulus asks for one.
  initial begin : receiver_pattern
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    bit          toggle;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    toggle = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 4);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      toggle = !toggle;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          3: out_stall <= toggle;
          default: out_stall <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  // Offer one item and wait for its transfer; bursts are broken by random gaps.
  task automatic send_item(logic [1:0] op, logic [7:0] value);
    in_item_t    item;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    item.opcode = op;
    item.byte_value = value;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_drained();
    int unsigned guard;
    guard = 0;
    while (sb.awaited_results.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic write_timeout(logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Build one exchange of the given shape and send it, with ticks and
  // ignored opcodes mixed in at times.
  task automatic run_exchange(exchange_kind_t kind, int forced_len = -1);
    logic [7:0]  bytes_q[$];
    int          len;
    int unsigned cut;
    int unsigned pos;
    logic [7:0]  sum;
    logic [7:0]  dcs;
    bit          bad_sum;
    bit          bad_ack;
    bit          bad_head;
    bit          ticky;
    bad_sum = (kind == EX_BAD_SUM) || (kind == EX_MIXED && $urandom_range(0, 1));
    bad_ack = (kind == EX_BAD_ACK) || (kind == EX_MIXED && $urandom_range(0, 1));
    bad_head = (kind == EX_BAD_HEAD) || (kind == EX_MIXED && $urandom_range(0, 1));
    case (kind)
      EX_ZERO:  len = 0;
      EX_LONG:  len = $urandom_range(144, 255);
      EX_SHORT: len = $urandom_range(1, 2);
      default: begin
        pos = $urandom_range(0, 9);
        if (pos < 7) len = $urandom_range(1, 20);
        else if (pos < 9) len = $urandom_range(21, 60);
        else len = $urandom_range(61, 143);
      end
    endcase
    if (forced_len >= 0) len = forced_len;

    // ACK, frame header, LEN and LCS.
    foreach (ACK_PATTERN[i]) bytes_q.push_back(ACK_PATTERN[i]);
    foreach (HEAD_PATTERN[i]) bytes_q.push_back(HEAD_PATTERN[i]);
    if (bad_ack) begin
      pos = $urandom_range(0, ACK_BYTES - 1);
      bytes_q[pos] = bytes_q[pos] ^ 8'($urandom_range(1, 255));
    end
    if (bad_head) begin
      pos = $urandom_range(ACK_BYTES, HEAD_END - 1);
      bytes_q[pos] = bytes_q[pos] ^ 8'($urandom_range(1, 255));
    end
    bytes_q.push_back(8'(len));
    bytes_q.push_back($urandom_range(0, 1) ? 8'(-len) : 8'($urandom_range(0, 255)));

    // A frame that cannot complete runs on until the buffer is full.
    if (len == 0 || len > BUFFER_BYTES - TAIL_BYTES) begin
      while (bytes_q.size() < BUFFER_BYTES) bytes_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      sum = '0;
      repeat (len) begin
        dcs = 8'($urandom_range(0, 255));
        sum += dcs;
        bytes_q.push_back(dcs);
      end
      dcs = -sum;
      if (bad_sum) dcs += 8'($urandom_range(1, 255));
      bytes_q.push_back(dcs);
      bytes_q.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)));
    end

    if (kind == EX_TRUNC || kind == EX_RESTART) begin
      cut = $urandom_range(1, bytes_q.size() - 1);
      while (bytes_q.size() > cut) void'(bytes_q.pop_back());
    end

    ticky = ($urandom_range(0, 3) == 0);
    send_item(OP_START, 8'($urandom_range(0, 255)));
    foreach (bytes_q[i]) begin
      if (ticky && $urandom_range(0, 15) == 0) send_item(OP_TICK, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 40) == 0) send_item(OP_UNUSED, 8'($urandom_range(0, 255)));
      send_item(OP_BYTE, bytes_q[i]);
    end
    items_done += bytes_q.size() + 1;

    // An unfinished exchange is left to time out where the limit is short.
    if (kind == EX_TRUNC) begin
      cut = (sb.timeout_limit <= 64) ? sb.timeout_limit : 3;
      if (cut == 0) cut = 1;
      repeat (cut) send_item(OP_TICK, 8'($urandom_range(0, 255)));
      items_done += cut;
    end

    // Now and then some stray traffic after the exchange.
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 2))
          0: send_item(OP_BYTE, 8'($urandom_range(0, 255)));
          1: send_item(OP_TICK, 8'($urandom_range(0, 255)));
          default: send_item(OP_UNUSED, 8'($urandom_range(0, 255)));
        endcase
      end
    end
  endtask

  // Main stimulus: directed items, then phases at several timeout settings.
  initial begin
    logic [15:0]    limit_plan [PHASE_COUNT];
    exchange_kind_t kind;
    int unsigned    pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    limit_plan[0] = TIMEOUT_RESET;
    limit_plan[1] = 16'hFFFF;
    limit_plan[2] = 16'h0000;
    limit_plan[3] = 16'd1;
    limit_plan[4] = 16'($urandom_range(3, 40));
    limit_plan[5] = 16'($urandom_range(41, 64));
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Traffic while idle is ignored; then a timeout at the reset limit.
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_TICK, 8'h00);
    send_item(OP_UNUSED, 8'hAA);
    send_item(OP_START, 8'h55);
    send_item(OP_TICK, 8'hFF);
    send_item(OP_UNUSED, 8'h00);
    send_item(OP_TICK, 8'h00);

    // Smallest frame that completes: LEN of one gives an empty payload.
    send_item(OP_START, 8'h00);
    foreach (ACK_PATTERN[i]) send_item(OP_BYTE, ACK_PATTERN[i]);
    foreach (HEAD_PATTERN[i]) send_item(OP_BYTE, HEAD_PATTERN[i]);
    send_item(OP_BYTE, 8'h01);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'h01);
    send_item(OP_BYTE, 8'h00);

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      if (ph != 0) begin
        release_input();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_timeout(limit_plan[ph]);
      end

      // Long receiver hold-off against a long payload, plus the size extremes.
      if (ph == 1) begin
        hold_request = 1'b1;
        run_exchange(EX_GOOD, 60);
        run_exchange(EX_ZERO);
        run_exchange(EX_LONG, 255);
        run_exchange(EX_GOOD, 143);
      end
      if (ph == PHASE_COUNT - 1) begin
        hold_request = 1'b1;
        run_exchange(EX_GOOD, 40);
        release_input();
        wait_drained();
      end

      while (items_done < ITEM_TARGET * (ph + 1) / PHASE_COUNT) begin
        pick = $urandom_range(0, 99);
        if (pick < 38) kind = EX_GOOD;
        else if (pick < 48) kind = EX_BAD_SUM;
        else if (pick < 56) kind = EX_BAD_ACK;
        else if (pick < 64) kind = EX_BAD_HEAD;
        else if (pick < 74) kind = EX_MIXED;
        else if (pick < 82) kind = EX_SHORT;
        else if (pick < 90) kind = EX_TRUNC;
        else if (pick < 99) kind = EX_RESTART;
        else kind = $urandom_range(0, 1) ? EX_ZERO : EX_LONG;
        run_exchange(kind);
      end
    end

    release_input();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.awaited_results.size() != 0) begin
      $error("%0d expected results never arrived", sb.awaited_results.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
